@@ design/atsb_pkg.sv @@
package atsb_pkg;

    localparam int MAX_FRAMES   = 16;
    localparam int WINDOW_SLOTS = 64;
    localparam int IDX_W        = $clog2(MAX_FRAMES);
    localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
    localparam int SEQ_W        = 12;
    localparam int LEN_W        = 12;
    localparam int TRY_W        = 4;
    localparam int WIN_W        = 7;
    localparam int BYTES_W      = 16;
    localparam int TOTAL_W      = 17;
    localparam int PAD_W        = 13;
    localparam int BA_BITS      = 64;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [7:0] CRC_INIT     = 8'hcf;
    localparam logic [7:0] CRC_HI_MASK  = 8'hc0;
    localparam logic [7:0] CRC_MID_MASK = 8'h30;

    typedef enum logic [1:0] {
        CMD_OFFER   = 2'd0,
        CMD_BA      = 2'd1,
        CMD_NO_BA   = 2'd2,
        CMD_SESSION = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OUT_ADMIT   = 3'd0,
        OUT_REFUSE  = 3'd1,
        OUT_ACKED   = 3'd2,
        OUT_RESEND  = 3'd3,
        OUT_DROPPED = 3'd4,
        OUT_IGNORED = 3'd5,
        OUT_SESSION = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        REG_WINDOW    = 2'd0,
        REG_MAX_BYTES = 2'd1,
        REG_DESC      = 2'd2,
        REG_MAX_TRIES = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   mpdu_len;
        logic [SEQ_W-1:0]   start_seq;
        logic [BA_BITS-1:0] ack_bitmap;
    } req_word_t;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [SEQ_W-1:0] out_seq;
        logic [15:0]      delim_length_field;
        logic [7:0]       hdr_crc;
        logic [PAD_W-1:0] padded_size;
        logic             last;
    } rsp_word_t;

    typedef struct packed {
        logic               ok;
        logic [SEQ_W-1:0]   first;
        logic [TOTAL_W-1:0] total;
        logic [PAD_W-1:0]   pad;
        logic [15:0]        dl;
        logic [7:0]         crc;
    } offer_res_t;

    typedef struct packed {
        outcome_t         outcome;
        logic [TRY_W-1:0] try_next;
    } entry_res_t;

    function automatic logic [7:0] half_crc(input logic [7:0] x);
        logic [7:0] c;
        c = x ^ {x[0], x[7:1]} ^ (x >> 2);
        if (x[1])
        begin
            c = c ^ CRC_HI_MASK;
        end
        c = c ^ ({x[3:0], 4'b0000} & CRC_MID_MASK);
        return c;
    endfunction

    function automatic logic [7:0] delimiter_crc(input logic [15:0] field);
        logic [7:0] crc;
        crc = CRC_INIT ^ half_crc(field[7:0]);
        crc = half_crc(crc) ^ half_crc(field[15:8]);
        return ~crc;
    endfunction

endpackage

@@ design/ampdu_tx_scoreboard_core.sv @@
// Transmit A-MPDU scoreboard for one traffic class. One command word is taken at a time:
// req_ready is high only while the core is idle. An offer, a session start or a stray
// block ack / no block ack passes through the decode and put states; its single response
// word is loaded in the put state once the output register is free.
// A block ack or no block ack with N MPDUs in flight returns N response words in
// admission order, the last one flagged; each entry costs a registered read of the
// in-flight sequence store followed by a registered read of the try-count store, and one
// shared judge unit decides acked, resend or dropped. Try counts live in a 64-entry RAM
// with per-slot valid bits, so reset and session start clear them at once and no clearing
// pass is needed. Configuration is to be written over the APB port only while the core
// is idle, which the core does not enforce; a response word waits in an output register.
module ampdu_tx_scoreboard_core
    import atsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_word_t           req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_word_t           rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_TRY_RD = 5'b00100,
        S_SETTLE = 5'b01000,
        S_PUT    = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    req_word_t               req_reg, req_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SEQ_W-1:0]        first_reg, first_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic                    closed_reg, closed_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [WINDOW_SLOTS-1:0] try_valid_reg, try_valid_next;
    rsp_word_t               pend_reg, pend_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_word_t               rsp_reg, rsp_next;

    logic [WIN_W-1:0]        window_reg;
    logic [BYTES_W-1:0]      max_bytes_reg;
    logic [7:0]              desc_reg;
    logic [TRY_W-1:0]        tries_reg;

    logic                    cfg_we;
    logic                    out_free;
    logic                    rsp_load;
    rsp_word_t               load_word;
    logic                    seq_we;
    logic [SEQ_W-1:0]        seq_rdata;
    logic                    try_we;
    logic [SLOT_W-1:0]       slot;
    logic [TRY_W-1:0]        try_rdata;
    logic [TRY_W-1:0]        try_count;
    logic                    entry_last;
    offer_res_t              offer;
    entry_res_t              entry;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WIN_W'(WINDOW_SLOTS);
            max_bytes_reg <= '1;
            desc_reg      <= '0;
            tries_reg     <= TRY_W'(4);
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_WINDOW:    window_reg    <= pwdata[WIN_W-1:0];
                REG_MAX_BYTES: max_bytes_reg <= pwdata[BYTES_W-1:0];
                REG_DESC:      desc_reg      <= pwdata[7:0];
                REG_MAX_TRIES: tries_reg     <= pwdata[TRY_W-1:0];
                default:       window_reg    <= window_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW:    prdata = PDATA_W'(window_reg);
            REG_MAX_BYTES: prdata = PDATA_W'(max_bytes_reg);
            REG_DESC:      prdata = PDATA_W'(desc_reg);
            REG_MAX_TRIES: prdata = PDATA_W'(tries_reg);
            default:       prdata = '0;
        endcase
    end

    atsb_offer_unit u_offer (
        .seq              (req_reg.seq),
        .mpdu_len         (req_reg.mpdu_len),
        .count            (count_reg),
        .first_seq        (first_reg),
        .total_bytes      (total_reg),
        .closed           (closed_reg),
        .window_size      (window_reg),
        .max_agg_bytes    (max_bytes_reg),
        .descriptor_bytes (desc_reg),
        .res              (offer)
    );

    atsb_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (MAX_FRAMES)
    ) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (req_reg.seq),
        .raddr (idx_next),
        .rdata (seq_rdata)
    );

    assign slot = seq_rdata[SLOT_W-1:0];

    atsb_ram #(
        .WIDTH (TRY_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_try_ram (
        .clk   (clk),
        .we    (try_we),
        .waddr (slot),
        .wdata (entry.try_next),
        .raddr (slot),
        .rdata (try_rdata)
    );

    assign try_count = try_valid_reg[slot] ? try_rdata : '0;

    atsb_entry_unit u_entry (
        .seq        (seq_rdata),
        .start_seq  (req_reg.start_seq),
        .ack_bitmap (req_reg.ack_bitmap),
        .have_ba    (req_reg.cmd == CMD_BA),
        .try_count  (try_count),
        .max_tries  (tries_reg),
        .res        (entry)
    );

    assign entry_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        closed_next    = closed_reg;
        idx_next       = idx_reg;
        try_valid_next = try_valid_reg;
        pend_next      = pend_reg;
        seq_we         = 1'b0;
        try_we         = 1'b0;
        rsp_load       = 1'b0;
        load_word      = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_PUT;
                case (req_reg.cmd)
                    CMD_OFFER:
                    begin
                        if (offer.ok)
                        begin
                            seq_we     = 1'b1;
                            first_next = offer.first;
                            count_next = count_reg + CNT_W'(1);
                            total_next = offer.total;
                            pend_next  = '{outcome: OUT_ADMIT, out_seq: req_reg.seq,
                                           delim_length_field: offer.dl,
                                           hdr_crc: offer.crc,
                                           padded_size: offer.pad, last: 1'b1};
                        end
                        else
                        begin
                            if (count_reg != '0)
                            begin
                                closed_next = 1'b1;
                            end
                            pend_next = '{outcome: OUT_REFUSE, out_seq: req_reg.seq,
                                          delim_length_field: '0, hdr_crc: '0,
                                          padded_size: '0, last: 1'b1};
                        end
                    end
                    CMD_BA, CMD_NO_BA:
                    begin
                        if (count_reg == '0)
                        begin
                            pend_next = '{outcome: OUT_IGNORED, out_seq: '0,
                                          delim_length_field: '0, hdr_crc: '0,
                                          padded_size: '0, last: 1'b1};
                        end
                        else
                        begin
                            state_next = S_TRY_RD;
                        end
                    end
                    CMD_SESSION:
                    begin
                        count_next     = '0;
                        first_next     = '0;
                        total_next     = '0;
                        closed_next    = 1'b0;
                        try_valid_next = '0;
                        pend_next      = '{outcome: OUT_SESSION, out_seq: '0,
                                           delim_length_field: '0, hdr_crc: '0,
                                           padded_size: '0, last: 1'b1};
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TRY_RD:
            begin
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                if (out_free)
                begin
                    rsp_load             = 1'b1;
                    load_word            = '{outcome: entry.outcome, out_seq: seq_rdata,
                                             delim_length_field: '0, hdr_crc: '0,
                                             padded_size: '0, last: entry_last};
                    try_we               = 1'b1;
                    try_valid_next[slot] = 1'b1;
                    if (entry_last)
                    begin
                        count_next  = '0;
                        first_next  = '0;
                        total_next  = '0;
                        closed_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TRY_RD;
                    end
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = load_word;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            first_reg     <= '0;
            total_reg     <= '0;
            closed_reg    <= 1'b0;
            idx_reg       <= '0;
            try_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            total_reg     <= total_next;
            closed_reg    <= closed_next;
            idx_reg       <= idx_next;
            try_valid_reg <= try_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("in-flight count above frame limit");

    a_closed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (count_reg != '0))
        else $error("closed aggregate with nothing in flight");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("new word taken while previous one is in progress");

    a_settle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SETTLE || state_reg == S_TRY_RD) |-> (count_reg != '0))
        else $error("settle walk with empty in-flight list");

    a_settle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SETTLE && rsp_load && entry_last)
            |=> (count_reg == '0 && state_reg == S_IDLE && rsp_valid && rsp.last))
        else $error("settle walk did not end cleanly");

endmodule

@@ design/atsb_ram.sv @@
module atsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/atsb_offer_unit.sv @@
module atsb_offer_unit
    import atsb_pkg::*;
(
    input  logic [SEQ_W-1:0]   seq,
    input  logic [LEN_W-1:0]   mpdu_len,
    input  logic [CNT_W-1:0]   count,
    input  logic [SEQ_W-1:0]   first_seq,
    input  logic [TOTAL_W-1:0] total_bytes,
    input  logic               closed,
    input  logic [WIN_W-1:0]   window_size,
    input  logic [BYTES_W-1:0] max_agg_bytes,
    input  logic [7:0]         descriptor_bytes,
    output offer_res_t         res
);

    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   limit;
    logic [SEQ_W-1:0]   first;
    logic [SEQ_W-1:0]   seq_gap;
    logic [TOTAL_W-1:0] base;
    logic [PAD_W-1:0]   len_p;
    logic [PAD_W-1:0]   pad;
    logic [TOTAL_W:0]   sum;
    logic [LEN_W-1:0]   len4;
    logic               empty;

    always_comb
    begin
        if (window_size == '0)
        begin
            win = WIN_W'(1);
        end
        else if (window_size > WIN_W'(WINDOW_SLOTS))
        begin
            win = WIN_W'(WINDOW_SLOTS);
        end
        else
        begin
            win = window_size;
        end
        limit = (win < WIN_W'(MAX_FRAMES)) ? win : WIN_W'(MAX_FRAMES);
        empty = (count == '0);
        first = empty ? seq : first_seq;
        base  = empty ? TOTAL_W'(descriptor_bytes) : total_bytes;
        len_p = PAD_W'(mpdu_len) + PAD_W'(11);
        pad   = {len_p[PAD_W-1:2], 2'b00};
        sum   = {1'b0, base} + (TOTAL_W + 1)'(pad);
        seq_gap = seq - first;
        len4  = mpdu_len + LEN_W'(4);

        res.ok    = !closed && (WIN_W'(count) < limit) && (seq_gap < SEQ_W'(win))
                    && (sum <= (TOTAL_W + 1)'(max_agg_bytes));
        res.first = first;
        res.total = sum[TOTAL_W-1:0];
        res.pad   = pad;
        res.dl    = {len4, 4'b0000};
        res.crc   = delimiter_crc({len4, 4'b0000});
    end

endmodule

@@ design/atsb_entry_unit.sv @@
module atsb_entry_unit
    import atsb_pkg::*;
(
    input  logic [SEQ_W-1:0]   seq,
    input  logic [SEQ_W-1:0]   start_seq,
    input  logic [BA_BITS-1:0] ack_bitmap,
    input  logic               have_ba,
    input  logic [TRY_W-1:0]   try_count,
    input  logic [TRY_W-1:0]   max_tries,
    output entry_res_t         res
);

    localparam int OFF_W = $clog2(BA_BITS);

    logic [SEQ_W-1:0] off;
    logic [TRY_W-1:0] t;
    logic             acked;

    always_comb
    begin
        off   = seq - start_seq;
        acked = have_ba && (off < SEQ_W'(BA_BITS)) && ack_bitmap[off[OFF_W-1:0]];
        t     = try_count + TRY_W'(1);
        if (acked)
        begin
            res.outcome  = OUT_ACKED;
            res.try_next = '0;
        end
        else if (t >= max_tries)
        begin
            res.outcome  = OUT_DROPPED;
            res.try_next = '0;
        end
        else
        begin
            res.outcome  = OUT_RESEND;
            res.try_next = t;
        end
    end

endmodule
